@@ src/qhsw_pkg.sv @@
// Shared types and constants for the quantized hard-swish block.
`default_nettype none
package qhsw_pkg;

    localparam int FRAC_BITS_DEFAULT = 24;
    localparam int SAMPLE_W          = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int BOUND_W           = 17;
    localparam int COEF_W            = 32;

    localparam logic [CFG_IDX_W-1:0] IDX_LOWER_BOUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_UPPER_BOUND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_QUAD_COEF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_LIN_COEF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_PASS_GAIN   = 3'd4;

    typedef struct packed {
        logic signed [BOUND_W-1:0] lower_bound;
        logic signed [BOUND_W-1:0] upper_bound;
        logic signed [COEF_W-1:0]  quad_coef;
        logic signed [COEF_W-1:0]  lin_coef;
        logic signed [COEF_W-1:0]  pass_gain;
    } cfg_t;

endpackage
`default_nettype wire

@@ src/qhsw_cfg.sv @@
// Configuration register file for the quantized hard-swish block.
`default_nettype none
module qhsw_cfg
    import qhsw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    localparam logic signed [COEF_W-1:0] GAIN_ONE = COEF_W'(64'sd1 <<< FRAC_BITS);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                IDX_LOWER_BOUND: cfg_next.lower_bound = cfg_wdata[BOUND_W-1:0];
                IDX_UPPER_BOUND: cfg_next.upper_bound = cfg_wdata[BOUND_W-1:0];
                IDX_QUAD_COEF:   cfg_next.quad_coef   = cfg_wdata[COEF_W-1:0];
                IDX_LIN_COEF:    cfg_next.lin_coef    = cfg_wdata[COEF_W-1:0];
                IDX_PASS_GAIN:   cfg_next.pass_gain   = cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower_bound <= '0;
            cfg_reg.upper_bound <= '0;
            cfg_reg.quad_coef   <= '0;
            cfg_reg.lin_coef    <= '0;
            cfg_reg.pass_gain   <= GAIN_ONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ src/qhsw_front.sv @@
// Front pipeline: region classification, squaring and coefficient products.
`default_nettype none
module qhsw_front
    import qhsw_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  cfg_t                            cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] in_sample,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [63:0]              out_prod_q,
    output logic signed [47:0]              out_prod_l
);

    typedef enum logic [1:0] {
        REGION_ZERO,
        REGION_MID,
        REGION_PASS
    } region_t;

    logic                         a_valid_reg;
    logic signed [SAMPLE_W-1:0]   x_reg;
    logic signed [2*SAMPLE_W-1:0] xsq_reg;
    logic signed [2*SAMPLE_W-1:0] xsq_next;
    region_t                      region_reg;
    region_t                      region_next;

    logic                         b_valid_reg;
    logic signed [63:0]           prod_q_reg;
    logic signed [63:0]           prod_q_next;
    logic signed [47:0]           prod_l_reg;
    logic signed [47:0]           prod_l_next;
    logic signed [COEF_W-1:0]     coef;

    logic                         adv_a;
    logic                         adv_b;
    logic signed [BOUND_W-1:0]    x_ext;

    assign adv_b    = !b_valid_reg || out_ready;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_ready = adv_a;

    always_comb begin
        x_ext    = BOUND_W'(in_sample);
        xsq_next = in_sample * in_sample;
        if (x_ext < cfg.lower_bound) begin
            region_next = REGION_ZERO;
        end else if (x_ext > cfg.upper_bound) begin
            region_next = REGION_PASS;
        end else begin
            region_next = REGION_MID;
        end
    end

    always_comb begin
        coef        = cfg.pass_gain;
        prod_q_next = '0;
        prod_l_next = '0;
        case (region_reg)
            REGION_MID: begin
                coef        = cfg.lin_coef;
                prod_q_next = cfg.quad_coef * xsq_reg;
                prod_l_next = coef * x_reg;
            end
            REGION_PASS: begin
                prod_l_next = coef * x_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                a_valid_reg <= in_valid;
            end
            if (adv_b) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            x_reg      <= in_sample;
            xsq_reg    <= xsq_next;
            region_reg <= region_next;
        end
        if (adv_b) begin
            prod_q_reg <= prod_q_next;
            prod_l_reg <= prod_l_next;
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_prod_q = prod_q_reg;
    assign out_prod_l = prod_l_reg;

endmodule
`default_nettype wire

@@ src/qhsw_back.sv @@
// Back pipeline: sum, scale with truncation toward zero, saturate to int16.
`default_nettype none
module qhsw_back
    import qhsw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [63:0]    in_prod_q,
    input  wire logic signed [47:0]    in_prod_l,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [SAMPLE_W-1:0] out_sample
);

    localparam logic signed [63:0] BIAS    = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam logic signed [63:0] SAT_MAX = 64'sd32767;
    localparam logic signed [63:0] SAT_MIN = -64'sd32768;

    logic                       c_valid_reg;
    logic signed [63:0]         sum_reg;
    logic signed [63:0]         sum_next;
    logic                       d_valid_reg;
    logic signed [63:0]         quot_reg;
    logic signed [63:0]         quot_next;
    logic signed [63:0]         biased;
    logic                       e_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;

    logic adv_c;
    logic adv_d;
    logic adv_e;

    assign adv_e    = !e_valid_reg || out_ready;
    assign adv_d    = !d_valid_reg || adv_e;
    assign adv_c    = !c_valid_reg || adv_d;
    assign in_ready = adv_c;

    always_comb begin
        sum_next = in_prod_q + 64'(in_prod_l);
        if (sum_reg[63]) begin
            biased = sum_reg + BIAS;
        end else begin
            biased = sum_reg;
        end
        quot_next = biased >>> FRAC_BITS;
        if (quot_reg > SAT_MAX) begin
            sample_next = SAT_MAX[SAMPLE_W-1:0];
        end else if (quot_reg < SAT_MIN) begin
            sample_next = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            sample_next = quot_reg[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (adv_c) begin
                c_valid_reg <= in_valid;
            end
            if (adv_d) begin
                d_valid_reg <= c_valid_reg;
            end
            if (adv_e) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_c) begin
            sum_reg <= sum_next;
        end
        if (adv_d) begin
            quot_reg <= quot_next;
        end
        if (adv_e) begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid  = e_valid_reg;
    assign out_sample = sample_reg;

endmodule
`default_nettype wire

@@ src/quantized_hard_swish.sv @@
// An accepted input passes register stages a, b, c, d and e on its way to m_tvalid.
// One sample per cycle unless m_tready stalls; five register stages each hold one sample.
// The x*x and coefficient multipliers and the 64-bit sum and bias adds set the stage depth.
// A stall at m_tready holds each full stage; empty stages keep filling.
// Reset is synchronous on aresetn low: all stages empty, config registers to reset values.
`default_nettype none
module quantized_hard_swish
    import qhsw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] sample_in
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata    // [15:0] sample_out
);

    cfg_t               cfg;
    logic               mid_valid;
    logic               mid_ready;
    logic signed [63:0] mid_prod_q;
    logic signed [47:0] mid_prod_l;
    logic signed [15:0] sample_out;

    qhsw_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    qhsw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  ($signed(s_tdata)),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_prod_q (mid_prod_q),
        .out_prod_l (mid_prod_l)
    );

    qhsw_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .in_prod_q  (mid_prod_q),
        .in_prod_l  (mid_prod_l),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (sample_out)
    );

    assign m_tdata = sample_out;

endmodule
`default_nettype wire

@@ src/qhsw_checker.sv @@
// Port-level checks for the quantized hard-swish block, with its bind.
`default_nettype none
module qhsw_checker
    import qhsw_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_wr_en,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [15:0]           s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [15:0]           m_tdata
);

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid just after reset");

    a_ready_when_drained: assert property (@(posedge aclk)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although the output stage can advance");

    a_no_result_from_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !$past(s_tvalid && s_tready, 5) && !$past(s_tvalid && s_tready, 4)
         && !$past(s_tvalid && s_tready, 3) && !$past(s_tvalid && s_tready, 2)
         && !$past(s_tvalid && s_tready, 1) && $past(aresetn, 5)
         && !$past(m_tvalid, 1) && !$past(m_tvalid, 2) && !$past(m_tvalid, 3)
         && !$past(m_tvalid, 4))
        |=> !m_tvalid)
        else $error("result appeared from an empty pipeline");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed while stalled");

endmodule

bind quantized_hard_swish qhsw_checker u_qhsw_checker (.*);
`default_nettype wire

@@ tb/sv/hard_swish_checker.sv @@
// Checker for the quantized hard-swish block: register mirror, predictor and result comparison.
`timescale 1ns / 100ps
module hard_swish_checker
    import qhsw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] sample_in
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [15:0]           m_tdata,   // [15:0] sample_out
    output int                         mismatches,
    output int                         outstanding,
    output int                         compared
);

    localparam longint UNITY = longint'(1) << FRAC_BITS;

    logic signed [BOUND_W-1:0] lower_lim;
    logic signed [BOUND_W-1:0] upper_lim;
    logic signed [COEF_W-1:0]  quad_k;
    logic signed [COEF_W-1:0]  lin_k;
    logic signed [COEF_W-1:0]  gain_k;

    logic [15:0] expected_samples[$];

    task automatic report(input string msg);
        if (mismatches < 20)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [15:0] hard_swish_of(input logic signed [15:0] x);
        longint xv;
        longint lo;
        longint hi;
        longint q;
        xv = x;
        lo = lower_lim;
        hi = upper_lim;
        if (xv < lo)
            q = 0;
        else if (xv > hi)
            q = (xv * longint'(gain_k)) / UNITY;
        else
            q = (longint'(quad_k) * (xv * xv) + longint'(lin_k) * xv) / UNITY;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            lower_lim = '0;
            upper_lim = '0;
            quad_k    = '0;
            lin_k     = '0;
            gain_k    = COEF_W'(UNITY);
            expected_samples.delete();
        end else begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                if (expected_samples.size() == 0) begin
                    report($sformatf("unexpected result transaction, sample_out %0d",
                                     $signed(m_tdata)));
                end else begin
                    want = expected_samples.pop_front();
                    compared++;
                    if (m_tdata !== want)
                        report($sformatf("sample_out %0d, expected %0d",
                                         $signed(m_tdata), $signed(want)));
                end
            end
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                expected_samples.push_back(hard_swish_of(s_tdata));
            if (cfg_wr_en) begin
                case (cfg_index)
                    IDX_LOWER_BOUND: lower_lim = cfg_wdata[BOUND_W-1:0];
                    IDX_UPPER_BOUND: upper_lim = cfg_wdata[BOUND_W-1:0];
                    IDX_QUAD_COEF:   quad_k    = cfg_wdata[COEF_W-1:0];
                    IDX_LIN_COEF:    lin_k     = cfg_wdata[COEF_W-1:0];
                    IDX_PASS_GAIN:   gain_k    = cfg_wdata[COEF_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = expected_samples.size();
    end

endmodule

@@ tb/sv/quantized_hard_swish_tb.sv @@
// Top of the quantized hard-swish testbench: clock, reset, stimulus, register settings and verdict.
`timescale 1ns / 100ps
module quantized_hard_swish_tb;
    import qhsw_pkg::*;

    typedef enum int {READY_FULL, READY_HALF, READY_MOSTLY, READY_STARVED} ready_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;   // [15:0] sample_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;        // [15:0] sample_out

    int mismatches;
    int outstanding;
    int compared;

    int          sent = 0;
    int          settings = 0;
    int          burst_left = 0;
    int          cur_lower = 0;
    int          cur_upper = 0;
    ready_mode_t ready_mode = READY_FULL;
    int          ready_left = 0;

    quantized_hard_swish dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    hard_swish_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(READY_FULL, READY_STARVED));
            ready_left = $urandom_range(10, 200);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            READY_FULL:   m_tready = 1'b1;
            READY_HALF:   m_tready = ($urandom_range(0, 1) == 1);
            READY_MOSTLY: m_tready = ($urandom_range(0, 7) != 0);
            default:      m_tready = ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [31:0] quad, input logic [31:0] lin,
                                 input logic [31:0] gain);
        write_reg(IDX_LOWER_BOUND, lo);
        write_reg(IDX_UPPER_BOUND, hi);
        write_reg(IDX_QUAD_COEF, quad);
        write_reg(IDX_LIN_COEF, lin);
        write_reg(IDX_PASS_GAIN, gain);
        cur_lower = $signed(lo[BOUND_W-1:0]);
        cur_upper = $signed(hi[BOUND_W-1:0]);
        settings++;
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    task automatic push_sample(input logic [15:0] x);
        int gap;
        s_tvalid = 1'b1;
        s_tdata  = x;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        sent++;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 5))
            0:       v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            1:       v = cur_lower + int'($urandom_range(0, 6)) - 3;
            2:       v = cur_upper + int'($urandom_range(0, 6)) - 3;
            3:       v = int'($urandom_range(0, 400)) - 200;
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [31:0] pick_coef();
        int v;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            1, 2, 3: v = int'($urandom_range(0, 1 << 27)) - (1 << 26);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_bound();
        int v;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = -65536;
                    1:       v = 65535;
                    2:       v = -32768;
                    3:       v = 32767;
                    default: v = 0;
                endcase
            end
            1, 2:    v = int'($urandom_range(0, 65535)) - 32768;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        #5_000_000;
        $display("timeout: %0d samples sent, %0d results outstanding", sent, outstanding);
        $display("quantized_hard_swish verification failed");
        $finish;
    end

    initial begin
        logic [31:0] lo_w;
        logic [31:0] hi_w;
        logic [31:0] swap_w;
        int          phase;
        int          waited;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: negative to zero, zero in the middle, positive at unity gain
        push_sample(16'h8000);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        push_sample(16'h0001);
        push_sample(16'h7FFF);

        // typical hard-swish shape, both bounds and their neighbours
        drain();
        apply_setting(32'hFFFF_F400, 32'h0000_0C00, 32'd2731, 32'h0080_0000, 32'h0100_0000);
        push_sample(16'h8000);
        push_sample(16'(cur_lower - 1));
        push_sample(16'(cur_lower));
        push_sample(16'h0000);
        push_sample(16'(cur_upper));
        push_sample(16'(cur_upper + 1));
        push_sample(16'h7FFF);

        // whole range quadratic with extreme coefficients: saturate to the largest value
        drain();
        apply_setting(32'hFFFF_0000, 32'h0000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0100_0000);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'hFFFF);
        push_sample(16'h0001);

        // crossed bounds, junk above bit 16, negative gain truncating toward zero
        drain();
        apply_setting(32'hFFFE_0064, 32'h0001_FF9C, 32'h0000_0000, 32'h0000_0000,
                      32'hFF7F_FFFF);
        write_reg(IDX_PASS_GAIN + 3'd1, 32'hFFFF_FFFF);
        write_reg(IDX_PASS_GAIN + 3'd2, 32'h1234_5678);
        write_reg(IDX_PASS_GAIN + 3'd3, 32'h0000_0000);
        push_sample(16'd99);
        push_sample(16'd100);
        push_sample(16'd101);
        push_sample(16'h7FFF);

        // everything on the gain path with the largest gain
        drain();
        apply_setting(32'hFFFF_0000, 32'hFFFF_7FFF, 32'h0000_0000, 32'h0000_0000,
                      32'h7FFF_FFFF);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0001);

        for (phase = 0; phase < 8; phase++) begin
            drain();
            lo_w = pick_bound();
            hi_w = pick_bound();
            if ($signed(lo_w[BOUND_W-1:0]) > $signed(hi_w[BOUND_W-1:0])
                    && $urandom_range(0, 2) != 0) begin
                swap_w = lo_w;
                lo_w   = hi_w;
                hi_w   = swap_w;
            end
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
                apply_setting(lo_w, hi_w, pick_coef(), pick_coef(), pick_coef());
            end else begin
                write_reg(IDX_LOWER_BOUND, lo_w);
                write_reg(IDX_UPPER_BOUND, hi_w);
                if ($urandom_range(0, 1) == 1)
                    write_reg(IDX_QUAD_COEF, pick_coef());
                if ($urandom_range(0, 1) == 1)
                    write_reg(IDX_LIN_COEF, pick_coef());
                if ($urandom_range(0, 1) == 1)
                    write_reg(IDX_PASS_GAIN, pick_coef());
                cur_lower = $signed(lo_w[BOUND_W-1:0]);
                cur_upper = $signed(hi_w[BOUND_W-1:0]);
                settings++;
            end
            if ($urandom_range(0, 1) == 1)
                write_reg(IDX_PASS_GAIN + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
            repeat (240) push_sample(pick_sample());
        end

        s_tvalid = 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < 10000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (20) @(negedge aclk);

        $display("%0d samples sent across %0d register settings, %0d results compared",
                 sent, settings, compared);
        $display("bounds crossed, equal and saturating, out-of-range register writes included");
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("quantized_hard_swish verification clean");
        end else begin
            $display("quantized_hard_swish verification failed");
        end
        $finish;
    end

endmodule
